/* design/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/dst_pkg.sv */
// Types, constants and saturating helpers for the delta statistics block
package dst_pkg;

  localparam int KEY_W = 64;
  localparam logic [5:0] TOP_COUNT_RESET = 6'd20;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REPORT = 2'd1,
    MODE_CLEAR  = 2'd2
  } dst_mode_t;

  typedef enum logic [1:0] {
    ROW_TOTALS = 2'd0,
    ROW_PHASE  = 2'd1,
    ROW_TOP    = 2'd2
  } dst_row_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_TOT,
    S_PH,
    S_TOP
  } dst_state_t;

  // input word payload, first field highest
  typedef struct packed {
    logic [6:0]         move_number;
    logic [31:0]        record_number;
    logic [3:0]         sample_phase;
    logic signed [15:0] candidate_raw_score;
    logic signed [15:0] normal_raw_score;
    logic signed [7:0]  candidate_score;
    logic signed [7:0]  normal_score;
  } dst_in_t;

  // output word payload, first field highest
  typedef struct packed {
    logic [15:0]        peak_or_phase;
    logic signed [63:0] extra_second;
    logic signed [63:0] extra_first;
    logic [46:0]        abs_raw_delta_value;
    logic signed [47:0] raw_delta_value;
    logic [46:0]        abs_delta_value;
    logic signed [47:0] delta_value;
    logic [7:0]         ply_or_peak;
    logic [31:0]        count_or_record;
    logic [4:0]         row_index;
  } dst_row_t;

  // per-entry payload of the ranked list
  typedef struct packed {
    logic [3:0]         phase;
    logic signed [7:0]  nscore;
    logic signed [15:0] nraw;
    logic               dneg;
    logic               rneg;
  } dst_val_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic rotate;
  } dst_cell_ctl_t;

  // one sample after the first stage
  typedef struct packed {
    logic signed [8:0]  d;
    logic [7:0]         ad;
    logic signed [16:0] rd;
    logic [16:0]        ard;
    logic [15:0]        sq_d;
    logic [31:0]        sq_r;
  } dst_sample_t;

  typedef struct packed {
    logic [31:0]        count;
    logic signed [47:0] s0;
    logic [46:0]        s1;
    logic signed [47:0] s2;
    logic [46:0]        s3;
  } dst_phase_t;

  typedef struct packed {
    dst_phase_t  sums;
    logic [62:0] q0;
    logic [62:0] q1;
    logic [7:0]  pk_d;
    logic [16:0] pk_r;
  } dst_totals_t;

  function automatic logic signed [47:0] sat_s48(logic signed [47:0] a,
                                                 logic signed [16:0] b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    if (s[48] != s[47]) sat_s48 = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else sat_s48 = s[47:0];
  endfunction

  function automatic logic [46:0] sat_u47(logic [46:0] a, logic [16:0] b);
    logic [47:0] s;
    s = 48'(a) + 48'(b);
    sat_u47 = s[47] ? {47{1'b1}} : s[46:0];
  endfunction

  function automatic logic [62:0] sat_u63(logic [62:0] a, logic [31:0] b);
    logic [63:0] s;
    s = 64'(a) + 64'(b);
    sat_u63 = s[63] ? {63{1'b1}} : s[62:0];
  endfunction

  function automatic logic [31:0] sat_inc32(logic [31:0] a);
    sat_inc32 = (&a) ? a : a + 32'd1;
  endfunction

endpackage

/* design/dst_cell.sv */
// One cell of the ranked list: holds an entry, inserts or shifts
module dst_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  dst_pkg::dst_cell_ctl_t   ctl,
  input  logic [dst_pkg::KEY_W-1:0] new_key,
  input  dst_pkg::dst_val_t        new_val,
  input  logic                     prev_stay,
  input  logic                     prev_valid,
  input  logic [dst_pkg::KEY_W-1:0] prev_key,
  input  dst_pkg::dst_val_t        prev_val,
  input  logic                     next_valid,
  input  logic [dst_pkg::KEY_W-1:0] next_key,
  input  dst_pkg::dst_val_t        next_val,
  output logic                     stay,
  output logic                     valid,
  output logic [dst_pkg::KEY_W-1:0] key,
  output dst_pkg::dst_val_t        val
);
  import dst_pkg::*;

  // entry keeps its place when it ranks at or above the new one
  assign stay = valid && (key >= new_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.insert && !stay) begin
      valid <= prev_stay ? 1'b1 : prev_valid;
    end else if (ctl.rotate) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert && !stay) begin
      key <= prev_stay ? new_key : prev_key;
      val <= prev_stay ? new_val : prev_val;
    end else if (ctl.rotate) begin
      key <= next_key;
      val <= next_val;
    end
  end

endmodule

/* design/dst_stats.sv */
// Totals, peaks and per-phase accumulators with saturation
module dst_stats #(
  parameter int PHASES = 16,
  parameter int PW     = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  add,
  input  dst_pkg::dst_sample_t  smp,
  input  logic [PW-1:0]         idx,
  output dst_pkg::dst_totals_t  totals,
  output dst_pkg::dst_phase_t   phase_row,
  output logic [PHASES-1:0]     nz
);
  import dst_pkg::*;

  dst_phase_t ph [PHASES];
  dst_phase_t ph_upd;

  assign phase_row = ph[idx];

  // nonzero-count flags per phase
  always_comb begin
    for (int p = 0; p < PHASES; p++) nz[p] = |ph[p].count;
  end

  always_comb begin
    ph_upd.count = sat_inc32(ph[idx].count);
    ph_upd.s0    = sat_s48(ph[idx].s0, 17'(smp.d));
    ph_upd.s1    = sat_u47(ph[idx].s1, 17'(smp.ad));
    ph_upd.s2    = sat_s48(ph[idx].s2, smp.rd);
    ph_upd.s3    = sat_u47(ph[idx].s3, smp.ard);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      totals <= '0;
      for (int p = 0; p < PHASES; p++) ph[p] <= '0;
    end else if (add) begin
      totals.sums.count <= sat_inc32(totals.sums.count);
      totals.sums.s0    <= sat_s48(totals.sums.s0, 17'(smp.d));
      totals.sums.s1    <= sat_u47(totals.sums.s1, 17'(smp.ad));
      totals.sums.s2    <= sat_s48(totals.sums.s2, smp.rd);
      totals.sums.s3    <= sat_u47(totals.sums.s3, smp.ard);
      totals.q0         <= sat_u63(totals.q0, 32'(smp.sq_d));
      totals.q1         <= sat_u63(totals.q1, smp.sq_r);
      if (smp.ad > totals.pk_d) totals.pk_d <= smp.ad;
      if (smp.ard > totals.pk_r) totals.pk_r <= smp.ard;
      ph[idx] <= ph_upd;
    end
  end

endmodule

/* design/delta_stats_top_k.sv */
// Add: score stage with squares, then accumulate and list insert; input waits meanwhile.
// Report: totals row, then the phase scan, then a rotation through the whole list; each
// row waits while the output is stalled; no new command is taken until the report ends.
// Clear acts on acceptance. List insert compares all cells at once in the cell chain.
// Synchronous reset clears all statistics, empties the list, top_count returns to 20.
module delta_stats_top_k #(
  parameter int PHASES    = 16,
  parameter int TOP_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // normal_score, candidate_score, normal_raw_score, candidate_raw_score,
  // sample_phase, record_number, move_number
  input  logic [95:0]  s_axis_tdata,
  // mode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // row_index, count_or_record, ply_or_peak, delta_value, abs_delta_value,
  // raw_delta_value, abs_raw_delta_value, extra_first, extra_second, peak_or_phase
  output logic [383:0] m_axis_tdata,
  // row_kind
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [5:0]   cfg_data
);
  import dst_pkg::*;

  localparam int PW = (PHASES > 1) ? $clog2(PHASES) : 1;
  localparam int RW = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
  localparam int FW = $clog2(TOP_DEPTH + 1);

  dst_state_t state, state_next;
  logic [5:0] top_count;
  logic [PW-1:0] pidx, pidx_next;
  logic [RW-1:0] r, r_next;
  logic [FW-1:0] fill, fill_next;

  dst_in_t in_w;
  dst_sample_t smp;
  logic [PW-1:0] smp_ph;
  logic [KEY_W-1:0] smp_key;
  dst_val_t smp_val;

  dst_cell_ctl_t ctl;
  logic st_add, st_clear;
  dst_totals_t totals;
  dst_phase_t phase_row;
  logic [PHASES-1:0] nz;

  logic load;
  dst_row_t row_n, row_q;
  dst_row_kind_t kind_n, kind_q;
  logic last_n, last_q;

  assign in_w = dst_in_t'(s_axis_tdata[90:0]);
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= TOP_COUNT_RESET;
    end else if (cfg_valid) begin
      top_count <= cfg_data;
    end
  end

  // first stage: deltas, magnitudes, squares, list key
  logic signed [8:0]  d_c;
  logic signed [16:0] rd_c;
  logic [8:0]         ad_c;
  logic [16:0]        ard_c;
  logic [4:0]         ph_c;
  always_comb begin
    d_c   = 9'(in_w.candidate_score) - 9'(in_w.normal_score);
    rd_c  = 17'(in_w.candidate_raw_score) - 17'(in_w.normal_raw_score);
    ad_c  = d_c[8] ? -d_c : d_c;
    ard_c = rd_c[16] ? -rd_c : rd_c;
    ph_c  = (5'(in_w.sample_phase) >= 5'(PHASES)) ? 5'(PHASES - 1) : 5'(in_w.sample_phase);
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      smp.d    <= d_c;
      smp.ad   <= ad_c[7:0];
      smp.rd   <= rd_c;
      smp.ard  <= ard_c;
      smp.sq_d <= ad_c[7:0] * ad_c[7:0];
      smp.sq_r <= ard_c[15:0] * ard_c[15:0];
      smp_ph   <= PW'(ph_c);
      smp_key  <= {ard_c, ad_c[7:0], ~in_w.record_number, ~in_w.move_number};
      smp_val  <= '{phase: ph_c[3:0], nscore: in_w.normal_score,
                    nraw: in_w.normal_raw_score, dneg: d_c[8], rneg: rd_c[16]};
    end
  end

  dst_stats #(.PHASES(PHASES), .PW(PW)) u_stats (
    .clk(clk), .rst(rst), .clear(st_clear), .add(st_add), .smp(smp),
    .idx((state == S_ADD) ? smp_ph : pidx),
    .totals(totals), .phase_row(phase_row), .nz(nz)
  );

  // ranked list as a chain of cells
  logic [TOP_DEPTH-1:0] c_valid, c_stay;
  logic [KEY_W-1:0] c_key [TOP_DEPTH];
  dst_val_t c_val [TOP_DEPTH];

  for (genvar i = 0; i < TOP_DEPTH; i++) begin : g_cell
    logic p_stay, p_valid, n_valid;
    logic [KEY_W-1:0] p_key, n_key;
    dst_val_t p_val, n_val;
    if (i == 0) begin : g_head
      assign p_stay  = 1'b1;
      assign p_valid = 1'b1;
      assign p_key   = smp_key;
      assign p_val   = smp_val;
    end else begin : g_body
      assign p_stay  = c_stay[i-1];
      assign p_valid = c_valid[i-1];
      assign p_key   = c_key[i-1];
      assign p_val   = c_val[i-1];
    end
    assign n_valid = c_valid[(i + 1) % TOP_DEPTH];
    assign n_key   = c_key[(i + 1) % TOP_DEPTH];
    assign n_val   = c_val[(i + 1) % TOP_DEPTH];
    dst_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .new_key(smp_key), .new_val(smp_val),
      .prev_stay(p_stay), .prev_valid(p_valid), .prev_key(p_key), .prev_val(p_val),
      .next_valid(n_valid), .next_key(n_key), .next_val(n_val),
      .stay(c_stay[i]), .valid(c_valid[i]), .key(c_key[i]), .val(c_val[i])
    );
  end

  // rows of the list a report emits
  logic [6:0] lim, n_top;
  always_comb begin
    lim   = (7'(top_count) > 7'(TOP_DEPTH)) ? 7'(TOP_DEPTH) : 7'(top_count);
    n_top = (lim < 7'(fill)) ? lim : 7'(fill);
  end

  // control state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pidx  <= '0;
      r     <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      pidx  <= pidx_next;
      r     <= r_next;
      fill  <= fill_next;
    end
  end

  // next state and datapath control
  logic slot;
  logic [7:0]  t_ad;
  logic [16:0] t_ard;
  always_comb begin
    slot = !m_axis_tvalid || m_axis_tready;
    t_ad  = c_key[0][46:39];
    t_ard = c_key[0][63:47];
    state_next = state;
    pidx_next  = pidx;
    r_next     = r;
    fill_next  = fill;
    ctl        = '0;
    st_add     = 1'b0;
    st_clear   = 1'b0;
    load       = 1'b0;
    row_n      = '0;
    kind_n     = ROW_TOTALS;
    last_n     = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (dst_mode_t'(s_axis_tuser))
            MODE_ADD:    state_next = S_ADD;
            MODE_REPORT: state_next = S_TOT;
            MODE_CLEAR: begin
              ctl.clear = 1'b1;
              st_clear  = 1'b1;
              fill_next = '0;
            end
            default: ;
          endcase
        end
      end
      S_ADD: begin
        st_add     = 1'b1;
        ctl.insert = 1'b1;
        if (7'(fill) < 7'(TOP_DEPTH)) fill_next = fill + 1'b1;
        state_next = S_IDLE;
      end
      S_TOT: begin
        if (slot) begin
          load   = 1'b1;
          kind_n = ROW_TOTALS;
          last_n = (nz == '0) && (n_top == 7'd0);
          row_n.count_or_record     = totals.sums.count;
          row_n.ply_or_peak         = totals.pk_d;
          row_n.delta_value         = totals.sums.s0;
          row_n.abs_delta_value     = totals.sums.s1;
          row_n.raw_delta_value     = totals.sums.s2;
          row_n.abs_raw_delta_value = totals.sums.s3;
          row_n.extra_first         = 64'(totals.q0);
          row_n.extra_second        = 64'(totals.q1);
          row_n.peak_or_phase       = totals.pk_r[15:0];
          pidx_next  = '0;
          state_next = S_PH;
        end
      end
      S_PH: begin
        if (!nz[pidx] || slot) begin
          if (nz[pidx]) begin
            load   = 1'b1;
            kind_n = ROW_PHASE;
            last_n = (((nz >> pidx) >> 1) == '0) && (n_top == 7'd0);
            row_n.row_index           = 5'(pidx);
            row_n.count_or_record     = phase_row.count;
            row_n.delta_value         = phase_row.s0;
            row_n.abs_delta_value     = phase_row.s1;
            row_n.raw_delta_value     = phase_row.s2;
            row_n.abs_raw_delta_value = phase_row.s3;
          end
          if (pidx == PW'(PHASES - 1)) begin
            r_next     = '0;
            state_next = S_TOP;
          end else begin
            pidx_next = pidx + 1'b1;
          end
        end
      end
      S_TOP: begin
        if (!(7'(r) < n_top) || slot) begin
          ctl.rotate = 1'b1;
          if (7'(r) < n_top) begin
            load   = 1'b1;
            kind_n = ROW_TOP;
            last_n = (7'(r) + 7'd1 == n_top);
            row_n.row_index           = 5'(r);
            row_n.count_or_record     = ~c_key[0][38:7];
            row_n.ply_or_peak         = {1'b0, ~c_key[0][6:0]};
            row_n.delta_value         = c_val[0].dneg ? -48'(t_ad) : 48'(t_ad);
            row_n.abs_delta_value     = 47'(t_ad);
            row_n.raw_delta_value     = c_val[0].rneg ? -48'(t_ard) : 48'(t_ard);
            row_n.abs_raw_delta_value = 47'(t_ard);
            row_n.extra_first         = 64'(c_val[0].nscore);
            row_n.extra_second        = 64'(c_val[0].nraw);
            row_n.peak_or_phase       = 16'(c_val[0].phase);
          end
          if (r == RW'(TOP_DEPTH - 1)) state_next = S_IDLE;
          else r_next = r + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_q  <= row_n;
      kind_q <= kind_n;
      last_q <= last_n;
    end
  end

  assign m_axis_tdata = {5'd0, row_q};
  assign m_axis_tuser = kind_q;
  assign m_axis_tlast = last_q;

endmodule

/* design/dst_checker.sv */
// Port-level checks on the delta statistics block, bound to the top level
`include "assert_macros.svh"

module dst_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [383:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  import dst_pkg::*;

  // a stalled result word keeps its payload
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output word changed")

  // no new command while a report still has rows to send
  `ASSERT_IMPLY(a_busy_report, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input taken in the middle of a report")

  // row kinds are only the three defined ones
  `ASSERT_IMPLY(a_row_kind, m_axis_tvalid, (m_axis_tuser == ROW_TOTALS) || (m_axis_tuser == ROW_PHASE) || (m_axis_tuser == ROW_TOP), "undefined row kind")

  // a report accepted is followed by a busy input side
  `ASSERT_NEXT(a_report_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_REPORT), !s_axis_tready, "input ready right after a report command")

endmodule

bind delta_stats_top_k dst_checker u_dst_checker (.*);

/* verif/testbench.sv */
// Self-checking testbench for the delta statistics and top-k block
`timescale 1ns / 100ps

module testbench;
  import dst_pkg::*;

  localparam int NPH = 16;
  localparam int DEPTH = 32;
  localparam longint S47MAX = 64'sd140737488355327;
  localparam longint S47MIN = -64'sd140737488355328;
  localparam longint U63MAX = 64'h7fff_ffff_ffff_ffff;

  typedef struct {
    logic [1:0] kind;
    logic       last;
    dst_row_t   row;
  } stat_row_t;

  // Predicts report rows from accepted commands and checks output words
  class stats_board;
    logic [5:0]  top_count;
    longint      cnt;
    longint      sums[4];
    longint      sq[2];
    longint      pk_d, pk_r;
    longint      ph_cnt[NPH];
    longint      ph_sums[NPH][4];
    logic [63:0] keys[$];
    dst_in_t     vals[$];
    stat_row_t   pending[$];
    int          errors;

    function void wipe();
      cnt = 0; pk_d = 0; pk_r = 0;
      foreach (sums[i]) sums[i] = 0;
      sq[0] = 0; sq[1] = 0;
      foreach (ph_cnt[p]) begin
        ph_cnt[p] = 0;
        for (int j = 0; j < 4; j++) ph_sums[p][j] = 0;
      end
      keys.delete(); vals.delete();
    endfunction

    function longint sat_s(longint a, longint b);
      longint r;
      r = a + b;
      if (r > S47MAX) return S47MAX;
      if (r < S47MIN) return S47MIN;
      return r;
    endfunction

    function longint sat_u(longint a, longint b);
      return (a + b > S47MAX) ? S47MAX : a + b;
    endfunction

    function void add_row(logic [1:0] k, int idx, longint c, longint pp, longint d,
                          longint ad, longint rd, longint ard, longint e1, longint e2,
                          longint pk);
      stat_row_t r;
      r.kind = k; r.last = 0;
      r.row.row_index = 5'(idx); r.row.count_or_record = 32'(c);
      r.row.ply_or_peak = 8'(pp);
      r.row.delta_value = 48'(d); r.row.abs_delta_value = 47'(ad);
      r.row.raw_delta_value = 48'(rd); r.row.abs_raw_delta_value = 47'(ard);
      r.row.extra_first = e1; r.row.extra_second = e2; r.row.peak_or_phase = 16'(pk);
      pending.insert(pending.size(), r);
    endfunction

    function void note_input(dst_mode_t m, dst_in_t s);
      longint d, rd, ad, ard;
      int p, pos;
      logic [63:0] key;
      if (m == MODE_CLEAR) wipe();
      else if (m == MODE_ADD) begin
        d = longint'(s.candidate_score) - longint'(s.normal_score);
        rd = longint'(s.candidate_raw_score) - longint'(s.normal_raw_score);
        ad = d < 0 ? -d : d;
        ard = rd < 0 ? -rd : rd;
        p = s.sample_phase;
        if (cnt < 64'hffff_ffff) cnt++;
        sums[0] = sat_s(sums[0], d); sums[1] = sat_u(sums[1], ad);
        sums[2] = sat_s(sums[2], rd); sums[3] = sat_u(sums[3], ard);
        sq[0] = (sq[0] + ad * ad > U63MAX) ? U63MAX : sq[0] + ad * ad;
        sq[1] = (sq[1] + ard * ard > U63MAX) ? U63MAX : sq[1] + ard * ard;
        if (ad > pk_d) pk_d = ad;
        if (ard > pk_r) pk_r = ard;
        if (ph_cnt[p] < 64'hffff_ffff) ph_cnt[p]++;
        ph_sums[p][0] = sat_s(ph_sums[p][0], d); ph_sums[p][1] = sat_u(ph_sums[p][1], ad);
        ph_sums[p][2] = sat_s(ph_sums[p][2], rd); ph_sums[p][3] = sat_u(ph_sums[p][3], ard);
        key = {ard[16:0], ad[7:0], ~s.record_number, ~s.move_number};
        pos = 0;
        while (pos < keys.size() && keys[pos] >= key) pos++;
        if (pos < DEPTH) begin
          keys.insert(pos, key); vals.insert(pos, s);
          if (keys.size() > DEPTH) begin
            void'(keys.pop_back()); void'(vals.pop_back());
          end
        end
      end else if (m == MODE_REPORT) begin
        int lim;
        add_row(ROW_TOTALS, 0, cnt, pk_d, sums[0], sums[1], sums[2], sums[3],
                sq[0], sq[1], pk_r);
        for (int q = 0; q < NPH; q++)
          if (ph_cnt[q] != 0)
            add_row(ROW_PHASE, q, ph_cnt[q], 0, ph_sums[q][0], ph_sums[q][1],
                    ph_sums[q][2], ph_sums[q][3], 0, 0, 0);
        lim = top_count > DEPTH ? DEPTH : top_count;
        for (int i = 0; i < lim && i < keys.size(); i++) begin
          longint ed, erd, ead, eard;
          eard = keys[i][63:47]; ead = keys[i][46:39];
          ed = longint'(vals[i].candidate_score) - longint'(vals[i].normal_score);
          erd = longint'(vals[i].candidate_raw_score) - longint'(vals[i].normal_raw_score);
          // record and ply are stored inverted in the key
          add_row(ROW_TOP, i, {~keys[i][38:7]}, {1'b0, ~keys[i][6:0]}, ed, ead, erd, eard,
                  longint'(vals[i].normal_score), longint'(vals[i].normal_raw_score),
                  vals[i].sample_phase);
        end
        pending[$].last = 1;
      end
    endfunction

    function void check_row(logic [1:0] k, logic l, dst_row_t r);
      stat_row_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected row kind=%0d %h", k, r);
        return;
      end
      e = pending.pop_front();
      if (e.kind !== k || e.last !== l || e.row !== r) begin
        errors++;
        if (errors <= 10)
          $display("row mismatch: exp kind=%0d last=%0d %h / got kind=%0d last=%0d %h",
                   e.kind, e.last, e.row, k, l, r);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [383:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [5:0]   cfg_data = '0;

  stats_board board;
  int         hold_off = 0;
  bit         mixed_stall = 1;

  always #5 clk = ~clk;

  delta_stats_top_k dut (.*);

  // output side: random stall pattern, plus long hold-off on request
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else m_axis_tready <= mixed_stall ? ($urandom_range(0, 3) != 0) : 1'b1;
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_row(m_axis_tuser, m_axis_tlast, m_axis_tdata[378:0]);
  end

  task automatic send_word(dst_mode_t m, dst_in_t s);
    s_axis_tvalid <= 1;
    s_axis_tuser <= m;
    s_axis_tdata <= {5'd0, s};
    do @(posedge clk); while (!s_axis_tready);
    board.note_input(m, s);
  endtask

  task automatic idle_sender(int n);
    s_axis_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    idle_sender(1);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_top_count(logic [5:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.top_count = v;
  endtask

  function automatic dst_in_t rand_sample(bit narrow);
    dst_in_t s;
    s = dst_in_t'(91'({$urandom, $urandom, $urandom}));
    if (narrow) begin
      s.normal_score = 8'($urandom_range(0, 128) - 64);
      s.candidate_score = 8'($urandom_range(0, 128) - 64);
      s.record_number = $urandom_range(0, 7);
      s.move_number = 7'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) s.candidate_raw_score = s.normal_raw_score;
    end
    return s;
  endfunction

  task automatic random_run(int n);
    int burst;
    dst_in_t s;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && n > 0; i++, n--) begin
        s = rand_sample($urandom_range(0, 1));
        case ($urandom_range(0, 19))
          0: send_word(MODE_REPORT, s);
          1: if ($urandom_range(0, 3) == 0) send_word(MODE_CLEAR, s);
             else send_word(MODE_ADD, s);
          2: send_word(dst_mode_t'(2'd3), s);
          default: send_word(MODE_ADD, s);
        endcase
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end
  endtask

  initial begin
    dst_in_t s;
    board = new();
    board.top_count = TOP_COUNT_RESET;
    board.wipe();
    board.errors = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // empty report, then field extremes and equal keys
    send_word(MODE_REPORT, '0);
    s = '0;
    s.normal_score = -128; s.candidate_score = 127;
    s.normal_raw_score = -32768; s.candidate_raw_score = 32767;
    s.sample_phase = 15; s.record_number = '1; s.move_number = '1;
    send_word(MODE_ADD, s);
    s.normal_score = 127; s.candidate_score = -128;
    s.normal_raw_score = 32767; s.candidate_raw_score = -32768;
    s.record_number = 0; s.move_number = 0; s.sample_phase = 0;
    send_word(MODE_ADD, s);
    send_word(MODE_ADD, s);
    s.record_number = 5;
    send_word(MODE_ADD, s);
    send_word(MODE_ADD, '0);
    send_word(dst_mode_t'(2'd3), s);
    send_word(MODE_REPORT, s);
    send_word(MODE_CLEAR, s);
    send_word(MODE_REPORT, s);
    drain();

    // list overflow with top_count above the depth, then zero
    write_top_count(6'd63);
    for (int i = 0; i < 36; i++) begin
      s = rand_sample(1);
      send_word(MODE_ADD, s);
    end
    send_word(MODE_REPORT, s);
    drain();
    write_top_count(6'd0);
    send_word(MODE_REPORT, s);
    drain();

    // output held off while inputs keep coming
    write_top_count(6'd32);
    hold_off = 400;
    random_run(60);
    send_word(MODE_REPORT, s);
    send_word(MODE_REPORT, s);
    drain();

    write_top_count(6'd1);
    mixed_stall = 0;
    random_run(80);
    send_word(MODE_REPORT, s);
    drain();

    write_top_count(6'd20);
    mixed_stall = 1;
    random_run(100);
    send_word(MODE_REPORT, s);
    drain();
    write_top_count(6'd31);
    random_run(60);
    send_word(MODE_REPORT, s);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

/* files.f */
+incdir+design
design/dst_pkg.sv
design/dst_cell.sv
design/dst_stats.sv
design/delta_stats_top_k.sv
design/dst_checker.sv
verif/testbench.sv
